/* hdl/nfsa_pkg.sv */
// Package with shared constants, types and controller encodings for the slot allocator.
package nfsa_pkg;

  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned LIM_W     = 9;
  localparam int unsigned MAX_SLOTS = 256;
  localparam int unsigned DEF_SLOTS = 256;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic init;
    logic free_req;
    logic alloc_start;
    logic alloc_fail;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic lim_zero;
    logic hit;
    logic exhausted;
  } sts_t;

endpackage

/* hdl/next_fit_slot_allocator.sv */
// Top level of the next-fit slot allocator.
// Usage:
// Requests arrive on the in channel (valid/ready): req_type_i selects allocate or free,
// and slot_id_i names the slot to free. Every request yields exactly one transfer on the
// out channel: granted_slot_o, success_o and free_count_o, held in an output register.
// The cfg channel writes the slot limit; each write reinitializes the pool with every
// slot free, the search position at zero and the free count equal to the limit.
// One request is worked on at a time. An allocate reads one flag per cycle from the
// flag RAM, starting at the search position; the RAM's single read port sets that
// rate. With a limit of zero an allocate is refused without a scan.
// A new request is taken as soon as the result sits in the output register.
// After reset every slot is free, the limit is 256 (clamped to SLOTS) and no clearing
// pass is needed. If the receiver stalls, the result waits in the output register; a
// following request is processed and then holds until that register drains.
module next_fit_slot_allocator #(
  parameter int unsigned SLOTS = nfsa_pkg::DEF_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [nfsa_pkg::SLOT_W-1:0]  slot_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [nfsa_pkg::SLOT_W-1:0]  granted_slot_o,
  output logic                         success_o,
  output logic [nfsa_pkg::LIM_W-1:0]   free_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [nfsa_pkg::LIM_W-1:0]   cfg_slot_limit_i
);
  import nfsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nfsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_slot_limit_i (cfg_slot_limit_i),
    .slot_id_i        (slot_id_i),
    .granted_slot_o   (granted_slot_o),
    .success_o        (success_o),
    .free_count_o     (free_count_o)
  );

endmodule

/* hdl/nfsa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module nfsa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/nfsa_datapath.sv */
// Datapath: slot flag RAM with valid bits, search position, free count and result registers.
module nfsa_datapath #(
  parameter int unsigned SLOTS = nfsa_pkg::DEF_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nfsa_pkg::cmd_t               cmd_i,
  output nfsa_pkg::sts_t               sts_o,
  input  logic [nfsa_pkg::LIM_W-1:0]   cfg_slot_limit_i,
  input  logic [nfsa_pkg::SLOT_W-1:0]  slot_id_i,
  output logic [nfsa_pkg::SLOT_W-1:0]  granted_slot_o,
  output logic                         success_o,
  output logic [nfsa_pkg::LIM_W-1:0]   free_count_o
);
  import nfsa_pkg::*;

  localparam int unsigned MaxLim = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
  localparam int unsigned AddrW  = $clog2(MaxLim);
  localparam logic [LIM_W-1:0] MaxLimV = LIM_W'(MaxLim);

  logic [LIM_W-1:0]  limit_q;
  logic [LIM_W-1:0]  total_q;
  logic [AddrW-1:0]  spos_q;
  logic [MaxLim-1:0] vld_q;
  logic [AddrW-1:0]  iss_q;
  logic [AddrW-1:0]  chk_q;
  logic [LIM_W-1:0]  checked_q;
  logic              rvld_q;
  logic [AddrW-1:0]  res_slot_q;
  logic              res_ok_q;
  logic [SLOT_W-1:0] granted_q;
  logic              success_q;
  logic [LIM_W-1:0]  free_count_q;

  logic              rdata;
  logic              used;
  logic              hit;
  logic              exhausted;
  logic              id_ok;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [AddrW-1:0]  raddr;
  logic [LIM_W-1:0]  checked_inc;
  logic [LIM_W-1:0]  eff_limit;

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] p,
                                                input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] s;
    s = LIM_W'(p) + LIM_W'(1);
    return (s >= lim) ? '0 : s[AddrW-1:0];
  endfunction

  always_comb begin
    used        = rvld_q & rdata;
    hit         = ~used;
    checked_inc = checked_q + LIM_W'(1);
    exhausted   = used && (checked_inc >= limit_q);
    id_ok       = LIM_W'(slot_id_i) < limit_q;
    we          = (cmd_i.scan & hit) | (cmd_i.free_req & id_ok);
    waddr       = cmd_i.scan ? chk_q : slot_id_i[AddrW-1:0];
    raddr       = cmd_i.alloc_start ? spos_q : iss_q;
    eff_limit   = (cfg_slot_limit_i > MaxLimV) ? MaxLimV : cfg_slot_limit_i;
  end

  assign sts_o.lim_zero  = (limit_q == '0);
  assign sts_o.hit       = hit;
  assign sts_o.exhausted = exhausted;

  nfsa_ram #(
    .WIDTH (1),
    .DEPTH (MaxLim)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.scan),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // A RAM entry counts only once its valid bit is set; until then the slot reads as free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= MaxLimV;
      total_q <= MaxLimV;
      spos_q  <= '0;
      vld_q   <= '0;
    end else if (cmd_i.init) begin
      limit_q <= eff_limit;
      total_q <= eff_limit;
      spos_q  <= '0;
      vld_q   <= '0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.scan && hit) begin
        spos_q <= wrap_inc(chk_q, limit_q);
        if (total_q != '0) begin
          total_q <= total_q - LIM_W'(1);
        end
      end
      if (cmd_i.free_req && id_ok && (total_q < limit_q)) begin
        total_q <= total_q + LIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rvld_q <= vld_q[raddr];
    if (cmd_i.alloc_start) begin
      iss_q     <= wrap_inc(spos_q, limit_q);
      chk_q     <= spos_q;
      checked_q <= '0;
    end else if (cmd_i.scan) begin
      iss_q     <= wrap_inc(iss_q, limit_q);
      chk_q     <= iss_q;
      checked_q <= checked_inc;
    end
    if (cmd_i.free_req) begin
      res_slot_q <= '0;
      res_ok_q   <= id_ok;
    end else if (cmd_i.alloc_fail) begin
      res_slot_q <= '0;
      res_ok_q   <= 1'b0;
    end else if (cmd_i.scan) begin
      if (hit) begin
        res_slot_q <= chk_q;
        res_ok_q   <= 1'b1;
      end else if (exhausted) begin
        res_slot_q <= '0;
        res_ok_q   <= 1'b0;
      end
    end
    if (cmd_i.load_out) begin
      granted_q    <= SLOT_W'(res_slot_q);
      success_q    <= res_ok_q;
      free_count_q <= total_q;
    end
  end

  assign granted_slot_o = granted_q;
  assign success_o      = success_q;
  assign free_count_o   = free_count_q;

endmodule

/* hdl/nfsa_ctrl.sv */
// Controller state machine sequencing requests, the allocate scan and the output transfer.
module nfsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           req_type_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nfsa_pkg::cmd_t cmd_o,
  input  nfsa_pkg::sts_t sts_i
);
  import nfsa_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = ~cfg_valid_i;
        cfg_ready_o = 1'b1;
        cmd_o.init  = cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          if (req_type_i == REQ_FREE) begin
            cmd_o.free_req = 1'b1;
            state_d        = ST_DONE;
          end else if (sts_i.lim_zero) begin
            cmd_o.alloc_fail = 1'b1;
            state_d          = ST_DONE;
          end else begin
            cmd_o.alloc_start = 1'b1;
            state_d           = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.exhausted) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* tb/slot_grant_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts every slot allocator response and compares it with the block's output.
module slot_grant_checker #(
  parameter int unsigned SLOTS = nfsa_pkg::DEF_SLOTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        req_type_i,
  input  logic [nfsa_pkg::SLOT_W-1:0] slot_id_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [nfsa_pkg::SLOT_W-1:0] granted_slot_i,
  input  logic                        success_i,
  input  logic [nfsa_pkg::LIM_W-1:0]  free_count_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [nfsa_pkg::LIM_W-1:0]  cfg_slot_limit_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  typedef struct packed {
    logic [nfsa_pkg::SLOT_W-1:0] slot;
    logic                        ok;
    logic [nfsa_pkg::LIM_W-1:0]  remaining;
  } grant_t;

  logic [nfsa_pkg::LIM_W-1:0] limit_q;
  bit                         free_map [nfsa_pkg::MAX_SLOTS];
  int unsigned                cursor;
  int unsigned                free_left;
  int unsigned                mismatches;
  grant_t                     grants_due [$];

  function automatic int unsigned active_limit();
    int unsigned lim;
    lim = limit_q;
    if (lim > SLOTS) lim = SLOTS;
    if (lim > nfsa_pkg::MAX_SLOTS) lim = nfsa_pkg::MAX_SLOTS;
    return lim;
  endfunction

  function automatic void reset_pool();
    for (int i = 0; i < nfsa_pkg::MAX_SLOTS; i++) free_map[i] = 1'b1;
    cursor    = 0;
    free_left = active_limit();
  endfunction

  function automatic grant_t predict_grant(input logic kind, input logic [7:0] id);
    grant_t      r;
    int unsigned lim;
    int unsigned pos;
    lim = active_limit();
    r   = '0;
    if (kind == nfsa_pkg::REQ_ALLOC) begin
      pos = cursor;
      for (int unsigned n = 0; n < lim && !r.ok; n++) begin
        if (pos >= lim) pos = 0;
        if (free_map[pos]) begin
          free_map[pos] = 1'b0;
          r.slot = pos[nfsa_pkg::SLOT_W-1:0];
          r.ok   = 1'b1;
          cursor = (pos + 1 >= lim) ? 0 : pos + 1;
          if (free_left > 0) free_left--;
        end else begin
          pos++;
        end
      end
    end else if (id < lim) begin
      free_map[id] = 1'b1;
      if (free_left < lim) free_left++;
      r.ok = 1'b1;
    end
    r.remaining = free_left[nfsa_pkg::LIM_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      limit_q = nfsa_pkg::DEF_SLOTS;
      reset_pool();
      grants_due.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (grants_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: response with no request outstanding: slot %0d success %0d free %0d",
                     $realtime, granted_slot_i, success_i, free_count_i);
          end
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          if (granted_slot_i !== want.slot || success_i !== want.ok ||
              free_count_i !== want.remaining) begin
            if (mismatches < 10) begin
              $display("%0t: response mismatch, expected slot %0d success %0d free %0d, got slot %0d success %0d free %0d",
                       $realtime, want.slot, want.ok, want.remaining,
                       granted_slot_i, success_i, free_count_i);
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        limit_q = cfg_slot_limit_i;
        reset_pool();
      end
      if (in_valid_i && in_ready_i) begin
        grants_due.push_back(predict_grant(req_type_i, slot_id_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= grants_due.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top that drives requests and slot limit writes into the slot allocator.
module tb;

  localparam int unsigned SLOT_COUNT  = nfsa_pkg::DEF_SLOTS;
  localparam int unsigned QUIET_LIMIT = 4000;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        req_type;
  logic [nfsa_pkg::SLOT_W-1:0] slot_id;
  logic                        out_valid;
  logic                        out_ready;
  logic [nfsa_pkg::SLOT_W-1:0] granted_slot;
  logic                        success;
  logic [nfsa_pkg::LIM_W-1:0]  free_count;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [nfsa_pkg::LIM_W-1:0]  cfg_limit;
  bit                          gaps_on;
  int unsigned                 fails;
  int unsigned                 pending;

  always #2 clk = ~clk;

  next_fit_slot_allocator #(
    .SLOTS(SLOT_COUNT)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_type),
    .slot_id_i       (slot_id),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .granted_slot_o  (granted_slot),
    .success_o       (success),
    .free_count_o    (free_count),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_slot_limit_i(cfg_limit)
  );

  slot_grant_checker #(
    .SLOTS(SLOT_COUNT)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .req_type_i      (req_type),
    .slot_id_i       (slot_id),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .granted_slot_i  (granted_slot),
    .success_i       (success),
    .free_count_i    (free_count),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_slot_limit_i(cfg_limit),
    .fail_count_o    (fails),
    .pending_o       (pending)
  );

  always @(negedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= 28) : 1'b1;
  end

  task automatic push_request(input logic kind, input logic [7:0] id);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 28) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    req_type <= kind;
    slot_id  <= id;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic load_limit(input logic [nfsa_pkg::LIM_W-1:0] value);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [nfsa_pkg::LIM_W-1:0] value, input int unsigned count,
                           input int unsigned alloc_pct);
    int unsigned span;
    int unsigned roll;
    span = (value > SLOT_COUNT) ? SLOT_COUNT : value;
    load_limit(value);
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        push_request(nfsa_pkg::REQ_ALLOC, 8'($urandom_range(0, 255)));
      end else if (roll < alloc_pct + (100 - alloc_pct) * 3 / 4 && span > 0) begin
        push_request(nfsa_pkg::REQ_FREE, 8'($urandom_range(0, span - 1)));
      end else begin
        push_request(nfsa_pkg::REQ_FREE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    req_type  = nfsa_pkg::REQ_ALLOC;
    slot_id   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_limit = '0;
    gaps_on   = 1'b1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // A free of an already free slot must not push the count above the limit.
    push_request(nfsa_pkg::REQ_FREE, 8'd255);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd255);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_FREE, 8'd1);
    push_request(nfsa_pkg::REQ_FREE, 8'd1);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_FREE, 8'd0);

    // With no slots every request is refused.
    load_limit(9'd0);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_FREE, 8'd0);
    push_request(nfsa_pkg::REQ_FREE, 8'd255);

    load_limit(9'd511);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_FREE, 8'd255);

    load_limit(9'd1);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_FREE, 8'd1);
    push_request(nfsa_pkg::REQ_FREE, 8'd0);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);

    // The search position wraps back to slot zero.
    load_limit(9'd2);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_FREE, 8'd0);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);
    push_request(nfsa_pkg::REQ_ALLOC, 8'd0);

    run_phase(9'd3, 60, 50);
    run_phase(9'd17, 100, 60);
    run_phase(9'd256, 300, 95);
    gaps_on = 1'b0;
    run_phase(9'd64, 120, 60);
    gaps_on = 1'b1;
    run_phase(9'($urandom_range(4, 255)), 100, 60);
    run_phase(9'($urandom_range(257, 511)), 30, 70);
    run_phase(9'd1, 20, 50);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
